// ===== rtl/epvf_pkg.sv =====
// ----------------------------------------------------------------------------
// epvf_pkg
// Shared widths, codes and types of the encoder position and velocity filter.
// ----------------------------------------------------------------------------
package epvf_pkg;

  localparam int CNT_W     = 32;
  localparam int DT_W      = 24;
  localparam int TAU_W     = 24;
  localparam int AFRAC     = 16;
  localparam int DIV_N_W   = 68;
  localparam int DIV_D_W   = 25;
  localparam int DIV_CNT_W = 7;
  localparam int CFG_A_W   = 8;
  localparam int CFG_D_W   = 32;

  localparam logic [1:0] CMD_UPDATE     = 2'd0;
  localparam logic [1:0] CMD_RESET_POS  = 2'd1;
  localparam logic [1:0] CMD_RESET_FILT = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_COUNTER_MAX = 8'd0;
  localparam logic [CFG_A_W-1:0] CFG_DIR_REV     = 8'd1;
  localparam logic [CFG_A_W-1:0] CFG_RAD_PER_TCK = 8'd2;
  localparam logic [CFG_A_W-1:0] CFG_TAU         = 8'd3;

  localparam logic [1:0] CONV_POS    = 2'd0;
  localparam logic [1:0] CONV_RAW    = 2'd1;
  localparam logic [1:0] CONV_SMOOTH = 2'd2;

  localparam logic [63:0] SAT_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_DLT1 = 17'h00002,
    ST_DLT2 = 17'h00004,
    ST_NUM  = 17'h00008,
    ST_DIVS = 17'h00010,
    ST_DIVW = 17'h00020,
    ST_FDIF = 17'h00040,
    ST_FHI  = 17'h00080,
    ST_FLO  = 17'h00100,
    ST_FSTP = 17'h00200,
    ST_FAPP = 17'h00400,
    ST_RMAG = 17'h00800,
    ST_RHI  = 17'h01000,
    ST_RLO  = 17'h02000,
    ST_RTOP = 17'h04000,
    ST_RSGN = 17'h08000,
    ST_OUT  = 17'h10000
  } state_t;

endpackage

// ===== rtl/epvf_in_if.sv =====
// ----------------------------------------------------------------------------
// epvf_in_if
// Input word channel: command, counter sample and elapsed time.
// ----------------------------------------------------------------------------
interface epvf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] counter_now;
  logic [23:0] dt_us;

  modport source (output valid, command, counter_now, dt_us, input ready);
  modport sink   (input valid, command, counter_now, dt_us, output ready);
endinterface

// ===== rtl/epvf_out_if.sv =====
// ----------------------------------------------------------------------------
// epvf_out_if
// Result word channel: position and speed estimates.
// ----------------------------------------------------------------------------
interface epvf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count_delta;
  logic signed [63:0] position_count;
  logic signed [63:0] position_rad_q32;
  logic signed [63:0] raw_speed_ticks_q16;
  logic signed [63:0] raw_speed_rad_q16;
  logic signed [63:0] smooth_speed_ticks_q16;
  logic signed [63:0] smooth_speed_rad_q16;
  logic               filter_seeded;

  modport source (output valid, count_delta, position_count, position_rad_q32,
                  raw_speed_ticks_q16, raw_speed_rad_q16, smooth_speed_ticks_q16,
                  smooth_speed_rad_q16, filter_seeded, input ready);
  modport sink   (input valid, count_delta, position_count, position_rad_q32,
                  raw_speed_ticks_q16, raw_speed_rad_q16, smooth_speed_ticks_q16,
                  smooth_speed_rad_q16, filter_seeded, output ready);
endinterface

// ===== rtl/epvf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// epvf_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface epvf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [31:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== rtl/encoder_position_velocity_filter_core.sv =====
// ----------------------------------------------------------------------------
// encoder_position_velocity_filter_core
// Encoder position accumulator with raw and low-pass filtered speed.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    word
//  in_ch    in   valid/ready  command, counter_now, dt_us
//  out_ch   out  valid/ready  count change, position, radians, raw and smooth speed
//  cfg_ch   in   valid/ready  register index, write data
//
// An update runs the sequencer through the bit-serial dividers (68 steps) and
// one shared 32x32 multiplier, adding the low-pass step when the filter is seeded
// and tau is nonzero. Reset commands and zero-time updates skip the dividers.
// Synchronous active-low reset restores register defaults and zeroes state.
// A finished word waits in the output register; the next input is taken
// meanwhile, and the sequencer holds at its output step until it drains.
// Register writes are taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module encoder_position_velocity_filter_core
  import epvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  epvf_in_if.sink     in_ch,
  epvf_out_if.source  out_ch,
  epvf_cfg_if.sink    cfg_ch
);

  state_t state_r;

  logic [CNT_W-1:0] counter_max_r;
  logic             dir_rev_r;
  logic [31:0]      rad_per_tick_r;
  logic [TAU_W-1:0] tau_r;

  logic [CNT_W-1:0] last_count_r;
  logic [63:0]      pos_r;
  logic [63:0]      raw_r;
  logic [63:0]      smooth_r;
  logic             seeded_r;

  logic [1:0]       cmd_r;
  logic [CNT_W-1:0] now_r;
  logic [DT_W-1:0]  dt_r;
  logic [32:0]      fwd_r;
  logic [32:0]      range_r;
  logic [31:0]      delta_r;
  logic [16:0]      alpha_r;
  logic [63:0]      d_r;
  logic             up_r;
  logic [63:0]      step_r;
  logic [63:0]      prod_r;
  logic [63:0]      hi_r;
  logic [63:0]      mag_r;
  logic             neg_r;
  logic [63:0]      rmag_r;
  logic [1:0]       conv_r;
  logic [63:0]      rad_pos_r;
  logic [63:0]      rad_raw_r;
  logic [63:0]      rad_smooth_r;

  logic             out_valid_r;
  logic             out_load;

  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod_nxt;

  logic [CNT_W-1:0] now_clamp;
  logic [CNT_W-1:0] last_clamp;
  logic [33:0]      d34;
  logic [31:0]      s32;
  logic [31:0]      delta_nxt;
  logic [31:0]      delta_mag;

  logic             div_start;
  logic             spd_busy;
  logic             alp_busy;
  logic [DIV_N_W-1:0] spd_quo;
  logic [DIV_N_W-1:0] alp_quo;
  logic [63:0]      spd_mag;
  logic [63:0]      raw_nxt;
  logic [63:0]      conv_src;
  logic [63:0]      top;
  logic [63:0]      rmag_nxt;
  logic [63:0]      rsgn;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign div_start    = (state_r == ST_DIVS);
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign now_clamp  = (in_ch.counter_now > counter_max_r) ? counter_max_r : in_ch.counter_now;
  assign last_clamp = (last_count_r > counter_max_r) ? counter_max_r : last_count_r;

  assign d34       = (fwd_r >= (range_r >> 1)) ? ({1'b0, fwd_r} - {1'b0, range_r})
                                               : {1'b0, fwd_r};
  assign s32       = d34[31:0];
  assign delta_nxt = !dir_rev_r ? s32 :
                     (s32 == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - s32);
  assign delta_mag = delta_r[31] ? (32'd0 - delta_r) : delta_r;

  assign spd_mag = (spd_quo[DIV_N_W-1:63] != '0) ? SAT_MAG : {1'b0, spd_quo[62:0]};
  assign raw_nxt = delta_r[31] ? (64'd0 - spd_mag) : spd_mag;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      ST_NUM: begin
        mul_a = delta_mag;
        mul_b = 32'd1000000;
      end
      ST_FHI: begin
        mul_a = d_r[63:32];
        mul_b = {15'd0, alpha_r};
      end
      ST_FLO: begin
        mul_a = d_r[31:0];
        mul_b = {15'd0, alpha_r};
      end
      ST_RHI: begin
        mul_a = mag_r[63:32];
        mul_b = rad_per_tick_r;
      end
      ST_RLO: begin
        mul_a = mag_r[31:0];
        mul_b = rad_per_tick_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (conv_r)
      CONV_POS: conv_src = pos_r;
      CONV_RAW: conv_src = raw_r;
      default:  conv_src = smooth_r;
    endcase
  end

  assign top      = hi_r + {32'd0, prod_r[63:32]};
  assign rmag_nxt = (conv_r != CONV_POS) ? top :
                    (top >= 64'h8000_0000) ? SAT_MAG : {top[31:0], prod_r[31:0]};
  assign rsgn     = neg_r ? (64'd0 - rmag_r) : rmag_r;

  epvf_div u_spd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({prod_r[51:0], 16'd0}),
    .divisor  ({1'b0, dt_r}),
    .busy     (spd_busy),
    .quotient (spd_quo)
  );

  epvf_div u_alp_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({28'd0, dt_r, 16'd0}),
    .divisor  ({1'b0, tau_r} + {1'b0, dt_r}),
    .busy     (alp_busy),
    .quotient (alp_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      counter_max_r  <= 32'd65535;
      dir_rev_r      <= 1'b0;
      rad_per_tick_r <= 32'd13176795;
      tau_r          <= '0;
      last_count_r   <= '0;
      pos_r          <= '0;
      raw_r          <= '0;
      smooth_r       <= '0;
      seeded_r       <= 1'b0;
      conv_r         <= CONV_POS;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.command;
            now_r   <= now_clamp;
            dt_r    <= in_ch.dt_us;
            state_r <= ST_DLT1;
          end
        end
        ST_DLT1: begin
          range_r <= {1'b0, counter_max_r} + 33'd1;
          fwd_r   <= (now_r >= last_clamp) ? {1'b0, now_r - last_clamp}
                     : ({1'b0, counter_max_r - last_clamp} + {1'b0, now_r} + 33'd1);
          state_r <= ST_DLT2;
        end
        ST_DLT2: begin
          conv_r <= CONV_POS;
          case (cmd_r)
            CMD_UPDATE: begin
              delta_r      <= delta_nxt;
              last_count_r <= now_r;
              pos_r        <= pos_r + {{32{delta_nxt[31]}}, delta_nxt};
              if (dt_r == '0) begin
                raw_r    <= '0;
                smooth_r <= '0;
                seeded_r <= 1'b0;
                state_r  <= ST_RMAG;
              end else begin
                state_r <= ST_NUM;
              end
            end
            CMD_RESET_POS: begin
              delta_r      <= 32'd0;
              last_count_r <= now_r;
              pos_r        <= '0;
              raw_r        <= '0;
              smooth_r     <= '0;
              seeded_r     <= 1'b0;
              state_r      <= ST_RMAG;
            end
            CMD_RESET_FILT: begin
              delta_r  <= 32'd0;
              smooth_r <= raw_r;
              seeded_r <= 1'b1;
              state_r  <= ST_RMAG;
            end
            default: begin
              delta_r <= 32'd0;
              state_r <= ST_RMAG;
            end
          endcase
        end
        ST_NUM: begin
          prod_r  <= prod_nxt;
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (!spd_busy && !alp_busy) begin
            raw_r   <= raw_nxt;
            alpha_r <= alp_quo[16:0];
            if (tau_r == '0 || !seeded_r) begin
              smooth_r <= raw_nxt;
              seeded_r <= 1'b1;
              state_r  <= ST_RMAG;
            end else begin
              state_r <= ST_FDIF;
            end
          end
        end
        ST_FDIF: begin
          up_r    <= ($signed(raw_r) >= $signed(smooth_r));
          d_r     <= ($signed(raw_r) >= $signed(smooth_r)) ? (raw_r - smooth_r)
                                                           : (smooth_r - raw_r);
          state_r <= ST_FHI;
        end
        ST_FHI: begin
          prod_r  <= prod_nxt;
          state_r <= ST_FLO;
        end
        ST_FLO: begin
          hi_r    <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= ST_FSTP;
        end
        ST_FSTP: begin
          step_r  <= (hi_r << (32 - AFRAC)) + (prod_r >> AFRAC);
          state_r <= ST_FAPP;
        end
        ST_FAPP: begin
          smooth_r <= up_r ? (smooth_r + step_r) : (smooth_r - step_r);
          state_r  <= ST_RMAG;
        end
        ST_RMAG: begin
          neg_r   <= conv_src[63];
          mag_r   <= conv_src[63] ? (64'd0 - conv_src) : conv_src;
          state_r <= ST_RHI;
        end
        ST_RHI: begin
          prod_r  <= prod_nxt;
          state_r <= ST_RLO;
        end
        ST_RLO: begin
          hi_r    <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= ST_RTOP;
        end
        ST_RTOP: begin
          rmag_r  <= rmag_nxt;
          state_r <= ST_RSGN;
        end
        ST_RSGN: begin
          case (conv_r)
            CONV_POS: begin
              rad_pos_r <= rsgn;
              conv_r    <= CONV_RAW;
              state_r   <= ST_RMAG;
            end
            CONV_RAW: begin
              rad_raw_r <= rsgn;
              conv_r    <= CONV_SMOOTH;
              state_r   <= ST_RMAG;
            end
            default: begin
              rad_smooth_r <= rsgn;
              conv_r       <= CONV_POS;
              state_r      <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          CFG_COUNTER_MAX: counter_max_r  <= cfg_ch.wdata;
          CFG_DIR_REV:     dir_rev_r      <= cfg_ch.wdata[0];
          CFG_RAD_PER_TCK: rad_per_tick_r <= cfg_ch.wdata;
          CFG_TAU: begin
            tau_r    <= cfg_ch.wdata[TAU_W-1:0];
            seeded_r <= 1'b0;
          end
          default: begin
            tau_r <= tau_r;
          end
        endcase
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.count_delta            <= delta_r;
      out_ch.position_count         <= pos_r;
      out_ch.position_rad_q32       <= rad_pos_r;
      out_ch.raw_speed_ticks_q16    <= raw_r;
      out_ch.raw_speed_rad_q16      <= rad_raw_r;
      out_ch.smooth_speed_ticks_q16 <= smooth_r;
      out_ch.smooth_speed_rad_q16   <= rad_smooth_r;
      out_ch.filter_seeded          <= seeded_r;
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result word raised outside the output step");

  a_seed_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == ST_DIVW) && state_r != ST_DIVW) |-> seeded_r)
    else $error("filter not seeded after a speed update");

  a_conv_index: assert property (@(posedge clk) disable iff (!rst_n)
    conv_r != 2'd3)
    else $error("conversion index out of range");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    spd_busy == alp_busy)
    else $error("dividers out of step");
`endif

endmodule

// ===== rtl/epvf_div.sv =====
// ----------------------------------------------------------------------------
// epvf_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module epvf_div
  import epvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               busy,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   trial;

  assign shifted  = {rem_r, quo_r[DIV_N_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_N_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy) begin
      if (!trial[DIV_D_W+1]) begin
        rem_r <= trial[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== tb/encoder_position_velocity_filter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_position_velocity_filter_core_tb
// Drives command, counter and elapsed-time words through the encoder core
// under several register settings with random idling on both channels.
// Every accepted input word is run through a bit-exact position and speed
// estimator, and each result word is checked field by field in order.
// ----------------------------------------------------------------------------
module encoder_position_velocity_filter_core_tb;
  import epvf_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] counter_now;
    logic [23:0] dt_us;
  } sample_t;

  typedef struct packed {
    logic [31:0] delta;
    logic [63:0] pos;
    logic [63:0] pos_rad;
    logic [63:0] raw;
    logic [63:0] raw_rad;
    logic [63:0] smooth;
    logic [63:0] smooth_rad;
    logic        seeded;
  } estimate_t;

  localparam logic [63:0] LOW32     = 64'h0000_0000_FFFF_FFFF;
  localparam int          WDOG_MAX  = 5000;
  localparam int          LONG_HOLD = 400;
  localparam int          SETTLE    = 120;

  logic clk;
  logic rst_n;

  epvf_in_if  in_ch();
  epvf_out_if out_ch();
  epvf_cfg_if cfg_ch();

  encoder_position_velocity_filter_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // estimator state and registers
  logic [31:0] m_cmax, m_rpt, m_tau, m_last;
  logic        m_rev, m_seeded;
  logic [63:0] m_pos, m_raw, m_smooth;

  sample_t   pending_q[$];
  estimate_t estimate_q[$];
  int        n_fail;
  int        idle_cycles;
  int        gap_cnt;
  int        hold_cnt;
  bit        calm;
  bit        hold_req;
  bit        hold_done;
  logic [31:0] gen_last;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [31:0] clamp_count(logic [31:0] v);
    return (v > m_cmax) ? m_cmax : v;
  endfunction

  function automatic logic [63:0] speed_to_rad(logic [63:0] v);
    logic [63:0] m, r;
    m = mag64(v);
    r = (m >> 32) * m_rpt + (((m & LOW32) * m_rpt) >> 32);
    return v[63] ? -r : r;
  endfunction

  function automatic logic [63:0] pos_to_rad(logic [63:0] p);
    logic [63:0] m, hi, lo, top, r;
    m   = mag64(p);
    hi  = (m >> 32) * m_rpt;
    lo  = (m & LOW32) * m_rpt;
    top = hi + (lo >> 32);
    r   = (top >= 64'h8000_0000) ? SAT_MAG : {top[31:0], lo[31:0]};
    return p[63] ? -r : r;
  endfunction

  function automatic logic [31:0] count_change(logic [31:0] now);
    logic [63:0] last, mx, range, fwd, d;
    logic [31:0] s;
    last  = clamp_count(m_last);
    mx    = m_cmax;
    range = mx + 1;
    fwd   = (now >= last) ? (now - last) : (mx - last) + now + 1;
    d     = (fwd >= range / 2) ? fwd - range : fwd;
    s     = d[31:0];
    if (m_rev) s = (s == 32'h8000_0000) ? 32'h7FFF_FFFF : -s;
    return s;
  endfunction

  function automatic logic [63:0] speed_q16(logic [31:0] delta, logic [63:0] dt);
    logic [63:0] m, num, q, r, v;
    m   = delta[31] ? {32'd0, -delta} : {32'd0, delta};
    num = m * 64'd1000000;
    q   = num / dt;
    r   = num % dt;
    v   = (q >= (64'd1 << 47)) ? SAT_MAG : (q << 16) + (r << 16) / dt;
    return delta[31] ? -v : v;
  endfunction

  function automatic void smooth_toward_raw(logic [63:0] dt);
    logic [63:0] alpha, d, stp;
    bit up;
    alpha = (dt << AFRAC) / ({32'd0, m_tau} + dt);
    up    = $signed(m_raw) >= $signed(m_smooth);
    d     = up ? m_raw - m_smooth : m_smooth - m_raw;
    stp   = (((d >> 32) * alpha) << (32 - AFRAC)) + (((d & LOW32) * alpha) >> AFRAC);
    m_smooth = up ? m_smooth + stp : m_smooth - stp;
  endfunction

  function automatic estimate_t estimate_step(sample_t s);
    estimate_t e;
    logic [31:0] now, delta;
    logic [63:0] dt;
    now   = clamp_count(s.counter_now);
    dt    = {40'd0, s.dt_us};
    delta = '0;
    case (s.command)
      CMD_UPDATE: begin
        delta  = count_change(now);
        m_last = now;
        m_pos  = m_pos + {{32{delta[31]}}, delta};
        if (dt == 0) begin
          m_raw = '0;
          m_smooth = '0;
          m_seeded = 1'b0;
        end else begin
          m_raw = speed_q16(delta, dt);
          if (m_tau == 0 || !m_seeded) begin
            m_smooth = m_raw;
            m_seeded = 1'b1;
          end else begin
            smooth_toward_raw(dt);
          end
        end
      end
      CMD_RESET_POS: begin
        m_last = now;
        m_pos = '0;
        m_raw = '0;
        m_smooth = '0;
        m_seeded = 1'b0;
      end
      CMD_RESET_FILT: begin
        m_smooth = m_raw;
        m_seeded = 1'b1;
      end
      default: ;
    endcase
    e.delta      = delta;
    e.pos        = m_pos;
    e.pos_rad    = pos_to_rad(m_pos);
    e.raw        = m_raw;
    e.raw_rad    = speed_to_rad(m_raw);
    e.smooth     = m_smooth;
    e.smooth_rad = speed_to_rad(m_smooth);
    e.seeded     = m_seeded;
    return e;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    n_fail++;
  endtask

  // random word shaped around the running counter value
  function automatic sample_t make_sample();
    sample_t s;
    logic [63:0] range, off;
    int k;
    range = {32'd0, m_cmax} + 1;
    k = $urandom_range(0, 99);
    s.command = CMD_UPDATE;
    if (k < 70) begin
      off = $urandom_range(0, 4000) % range;
      if ($urandom_range(0, 1)) s.counter_now = 32'((gen_last + off) % range);
      else s.counter_now = 32'((gen_last + range - off) % range);
    end else if (k < 82) begin
      s.counter_now = $urandom;
    end else if (k < 88) begin
      s.counter_now = (m_cmax == 32'hFFFF_FFFF) ? $urandom :
                      m_cmax + 32'($urandom_range(1, 32'hFFFF_FFFF - m_cmax));
    end else if (k < 94) begin
      s.command = CMD_RESET_POS;
      s.counter_now = $urandom;
    end else if (k < 98) begin
      s.command = CMD_RESET_FILT;
      s.counter_now = $urandom;
    end else begin
      s.command = 2'd3;
      s.counter_now = $urandom;
    end
    k = $urandom_range(0, 99);
    if (k < 5) s.dt_us = '0;
    else if (k < 10) s.dt_us = 24'hFF_FFFF;
    else if (k < 18) s.dt_us = 24'($urandom);
    else if (k < 22) s.dt_us = 24'd1;
    else s.dt_us = 24'($urandom_range(100, 5000));
    if (s.command == CMD_UPDATE) gen_last = clamp_count(s.counter_now);
    return s;
  endfunction

  task automatic push_sample(logic [1:0] c, logic [31:0] n, logic [23:0] d);
    sample_t s;
    s.command = c;
    s.counter_now = n;
    s.dt_us = d;
    pending_q.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || estimate_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_ch.addr  <= idx;
    cfg_ch.wdata <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_COUNTER_MAX: m_cmax = val;
      CFG_DIR_REV:     m_rev = val[0];
      CFG_RAD_PER_TCK: m_rpt = val;
      CFG_TAU: begin
        m_tau = {8'd0, val[23:0]};
        m_seeded = 1'b0;
      end
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_q.push_back(make_sample());
    wait_drained();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        estimate_q.push_back(estimate_step({in_ch.command, in_ch.counter_now, in_ch.dt_us}));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          gap_cnt <= $urandom_range(1, 18);
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          sample_t s;
          s = pending_q.pop_front();
          in_ch.command <= s.command;
          in_ch.counter_now <= s.counter_now;
          in_ch.dt_us <= s.dt_us;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= (hold_cnt == 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(1, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (estimate_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        n_fail++;
      end else begin
        estimate_t e;
        e = estimate_q.pop_front();
        if (out_ch.count_delta !== e.delta)
          report_mismatch("count_delta", {32'd0, out_ch.count_delta}, {32'd0, e.delta});
        if (out_ch.position_count !== e.pos)
          report_mismatch("position_count", out_ch.position_count, e.pos);
        if (out_ch.position_rad_q32 !== e.pos_rad)
          report_mismatch("position_rad_q32", out_ch.position_rad_q32, e.pos_rad);
        if (out_ch.raw_speed_ticks_q16 !== e.raw)
          report_mismatch("raw_speed_ticks_q16", out_ch.raw_speed_ticks_q16, e.raw);
        if (out_ch.raw_speed_rad_q16 !== e.raw_rad)
          report_mismatch("raw_speed_rad_q16", out_ch.raw_speed_rad_q16, e.raw_rad);
        if (out_ch.smooth_speed_ticks_q16 !== e.smooth)
          report_mismatch("smooth_speed_ticks_q16", out_ch.smooth_speed_ticks_q16, e.smooth);
        if (out_ch.smooth_speed_rad_q16 !== e.smooth_rad)
          report_mismatch("smooth_speed_rad_q16", out_ch.smooth_speed_rad_q16, e.smooth_rad);
        if (out_ch.filter_seeded !== e.seeded)
          report_mismatch("filter_seeded", {63'd0, out_ch.filter_seeded}, {63'd0, e.seeded});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    n_fail = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_UPDATE;
    in_ch.counter_now = '0;
    in_ch.dt_us = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = CFG_COUNTER_MAX;
    cfg_ch.wdata = '0;
    m_cmax = 32'd65535;
    m_rev = 1'b0;
    m_rpt = 32'd13176795;
    m_tau = '0;
    m_last = '0;
    m_pos = '0;
    m_raw = '0;
    m_smooth = '0;
    m_seeded = 1'b0;
    gen_last = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under reset settings
    push_sample(CMD_UPDATE, 32'd0, 24'd1000);
    push_sample(CMD_UPDATE, 32'd65535, 24'd1000);
    push_sample(CMD_UPDATE, 32'd3, 24'd1);
    push_sample(CMD_UPDATE, 32'd32771, 24'd500);
    push_sample(CMD_UPDATE, 32'd32770, 24'hFF_FFFF);
    push_sample(CMD_UPDATE, 32'd40000, 24'd0);
    push_sample(CMD_UPDATE, 32'hFFFF_FFFF, 24'd200);
    push_sample(CMD_RESET_FILT, 32'd0, 24'd0);
    push_sample(CMD_RESET_POS, 32'd100, 24'd0);
    push_sample(CMD_UPDATE, 32'd90, 24'd10);
    push_sample(2'd3, 32'hFFFF_FFFF, 24'hFF_FFFF);
    push_sample(CMD_UPDATE, 32'd65535, 24'd7);
    wait_drained();

    write_reg(CFG_COUNTER_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_DIR_REV, 32'd1);
    write_reg(CFG_RAD_PER_TCK, 32'hFFFF_FFFF);
    push_sample(CMD_RESET_POS, 32'd0, 24'd0);
    push_sample(CMD_UPDATE, 32'h8000_0000, 24'd1);
    push_sample(CMD_UPDATE, 32'h0000_0000, 24'd1);
    push_sample(CMD_UPDATE, 32'h8000_0000, 24'hFF_FFFF);
    push_sample(CMD_UPDATE, 32'hFFFF_FFFF, 24'd3);
    push_sample(CMD_UPDATE, 32'h7FFF_FFFE, 24'd2);
    wait_drained();
    gen_last = clamp_count(32'h7FFF_FFFE);
    random_phase(200);

    write_reg(CFG_TAU, 32'd2000);
    write_reg(CFG_DIR_REV, 32'd0);
    write_reg(CFG_RAD_PER_TCK, 32'd1);
    hold_req = 1'b1;
    random_phase(250);

    write_reg(CFG_COUNTER_MAX, 32'd0);
    write_reg(CFG_TAU, 32'hFF_FFFF);
    random_phase(120);

    write_reg(CFG_COUNTER_MAX, 32'd1);
    write_reg(CFG_RAD_PER_TCK, 32'd13176795);
    write_reg(CFG_TAU, 32'd0);
    random_phase(150);

    write_reg(CFG_COUNTER_MAX, 32'd4095);
    write_reg(CFG_DIR_REV, 32'd1);
    write_reg(CFG_TAU, 32'd1);
    random_phase(300);

    write_reg(CFG_COUNTER_MAX, 32'd65535);
    write_reg(CFG_TAU, 32'd500);
    write_reg(CFG_RAD_PER_TCK, 32'h8000_0001);
    random_phase(300);

    calm = 1'b1;
    write_reg(CFG_COUNTER_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_DIR_REV, 32'd0);
    write_reg(CFG_TAU, 32'd10000);
    random_phase(300);

    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
